/* hdl/terrain_height_grid_engine_unit_macros.svh */
// Assertion macros for the terrain height grid engine.
// Bodies refer to clk and rst_n of the module that uses them.
`ifndef TERRAIN_HEIGHT_GRID_ENGINE_UNIT_MACROS_SVH
`define TERRAIN_HEIGHT_GRID_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define THGE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("thge assertion failed");

// Next-cycle implication, checked outside reset.
`define THGE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("thge assertion failed");

`endif

/* hdl/thge_pkg.sv */
// Shared types and constants of the terrain height grid engine.
// No dependencies; the engine unit imports it.
`default_nettype none
package thge_pkg;

  localparam int GRID_CELLS     = 4096;
  localparam int MAX_SIDE_CELLS = 32;

  localparam int ADDR_W = $clog2(GRID_CELLS);
  localparam int SIDE_W = $clog2(MAX_SIDE_CELLS) + 1;
  localparam int CNT_W  = 2 * $clog2(MAX_SIDE_CELLS) + 1;
  localparam int SUM_W  = 16 + 2 * $clog2(MAX_SIDE_CELLS);
  localparam int DCNT_W = $clog2(SUM_W);
  localparam int ACC_W  = 12 + $clog2(MAX_SIDE_CELLS);
  localparam int OFF_W  = (ACC_W + 3 > 20) ? ACC_W + 3 : 20;
  localparam int Q_W    = OFF_W + 2;

  localparam logic signed [15:0] OUTSIDE_DEPTH = -16'sd16000;
  localparam logic signed [16:0] HALF_UNIT     = 17'sd8;
  localparam logic signed [16:0] NEAR_LIMIT    = 17'sd32;
  localparam logic [10:0]        QUERY_SPAN    = 11'd16;
  localparam logic [11:0]        QUERY_STEP    = 12'd8;

  typedef enum logic [2:0] {
    MODE_WRITE = 3'd0,
    MODE_RESET = 3'd1,
    MODE_RAISE = 3'd2,
    MODE_MAXB  = 3'd3,
    MODE_MAXO  = 3'd4,
    MODE_AVG   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_OUTSIDE = 2'd1,
    STAT_SKIP    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CFG_MIN_X      = 3'd0,
    CFG_MAX_X      = 3'd1,
    CFG_MIN_Z      = 3'd2,
    CFG_MAX_Z      = 3'd3,
    CFG_CELL_SIZE  = 3'd4,
    CFG_CELL_SCALE = 3'd5,
    CFG_ROW_LENGTH = 3'd6,
    CFG_ROW_COUNT  = 3'd7
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COPY,
    ST_OFF,
    ST_MUL,
    ST_LIN,
    ST_IDX,
    ST_DAT,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

/* hdl/thge_if.sv */
// Valid/ready channel interfaces for the request and result items.
// Depends on nothing but the field widths of the engine.
`default_nettype none
interface thge_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_z;
  logic [10:0]        span;
  logic signed [15:0] height;
  logic [11:0]        cell_index;
  logic signed [15:0] cell_value;

  modport source (output valid, mode, pos_x, pos_z, span, height, cell_index, cell_value,
                  input ready);
  modport sink (input valid, mode, pos_x, pos_z, span, height, cell_index, cell_value,
                output ready);
endinterface

interface thge_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] depth;
  logic [1:0]         status;

  modport source (output valid, depth, status, input ready);
  modport sink (input valid, depth, status, output ready);
endinterface
`default_nettype wire

/* hdl/terrain_height_grid_engine_unit.sv */
// Each sample passes through the offset, two multiply, address and read states. A raise
// first reads the centre cell and then walks the samples; an average ends with a divide, and
// an overlay reset copies min(rows*cols, GRID_CELLS) cells from the base grid. One item is in
// work at a time; the next is taken while a result waits, and a result that is not taken
// holds the engine in its last state.
// Reset (synchronous, rst_n low) clears control state and loads register defaults.
`default_nettype none
`include "terrain_height_grid_engine_unit_macros.svh"
module terrain_height_grid_engine_unit (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [15:0]     cfg_data,
  thge_in_if.sink              in_item,
  thge_out_if.source           out_item
);
  import thge_pkg::*;

  // Configuration registers.
  logic signed [15:0] min_x_r, max_x_r, min_z_r, max_z_r;
  logic [11:0]        cell_size_r;
  logic [15:0]        cell_scale_r;
  logic [12:0]        row_length_r, row_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r <= '0; max_x_r <= '0; min_z_r <= '0; max_z_r <= '0;
      cell_size_r <= 12'd16; cell_scale_r <= 16'd256;
      row_length_r <= 13'd64; row_count_r <= 13'd64;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_MIN_X:      min_x_r <= cfg_data;
        CFG_MAX_X:      max_x_r <= cfg_data;
        CFG_MIN_Z:      min_z_r <= cfg_data;
        CFG_MAX_Z:      max_z_r <= cfg_data;
        CFG_CELL_SIZE:  cell_size_r <= cfg_data[11:0];
        CFG_CELL_SCALE: cell_scale_r <= cfg_data;
        CFG_ROW_LENGTH: row_length_r <= cfg_data[12:0];
        CFG_ROW_COUNT:  row_count_r <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Working registers.
  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  logic signed [17:0] ox2_r, ox2_nxt, oz2_r, oz2_nxt;
  logic [10:0] span_r, span_nxt;
  logic [11:0] step_r, step_nxt;
  logic signed [15:0] hgt_r, hgt_nxt, best_r, best_nxt, dep_r, dep_nxt;
  logic center_r, center_nxt, skip_r, skip_nxt, outside_r, outside_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SIDE_W-1:0] bx_r, bx_nxt, az_r, az_nxt;
  logic [ACC_W-1:0] accx_r, accx_nxt, accz_r, accz_nxt;
  logic signed [OFF_W-1:0] offx_r, offx_nxt, offz_r, offz_nxt;
  logic [Q_W-1:0] qx_r, qx_nxt, qz_r, qz_nxt;
  logic negx_r, negx_nxt, negz_r, negz_nxt;
  logic [12:0] i_r, i_nxt;
  logic [25:0] jrl_r, jrl_nxt;
  logic lok_r, lok_nxt, sok_r, sok_nxt;
  logic [ADDR_W-1:0] lin_r, lin_nxt;
  logic [25:0] prod_r, prod_nxt;
  logic [ADDR_W:0] k_r, k_nxt;
  logic cp_wr_r, cp_wr_nxt;
  logic [ADDR_W-1:0] cp_wa_r, cp_wa_nxt;
  logic [SUM_W-1:0] dvd_r, dvd_nxt, quo_r, quo_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic dneg_r, dneg_nxt;
  logic out_valid_r, out_valid_nxt;
  logic signed [15:0] out_depth_r, out_depth_nxt;
  logic [1:0] out_status_r, out_status_nxt;

  // Memory ports.
  logic [ADDR_W-1:0] rd_addr, base_wa, ov_wa;
  logic base_we, ov_we;
  logic signed [15:0] base_wd, ov_wd, base_q_r, ov_q_r;
  logic signed [15:0] base_mem [GRID_CELLS];
  logic signed [15:0] ov_mem [GRID_CELLS];

  always_ff @(posedge clk) begin
    if (base_we) base_mem[base_wa] <= base_wd;
    base_q_r <= base_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ov_we) ov_mem[ov_wa] <= ov_wd;
    ov_q_r <= ov_mem[rd_addr];
  end

  // Datapath helpers.
  logic signed [16:0] px17, pz17;
  logic query_out;
  logic [ADDR_W:0] copy_lim;
  logic signed [OFF_W-1:0] dx_s, dz_s;
  logic [OFF_W+14:0] px_prod, pz_prod;
  logic [26:0] lin_full;
  logic signed [16:0] near_d, raised;
  logic [SIDE_W-1:0] bx_inc, az_inc;
  logic [ACC_W-1:0] accx_inc, accz_inc;
  logic row_end, col_end;
  logic signed [SUM_W-1:0] sum_upd;
  logic [CNT_W-1:0] cnt_upd;
  logic [CNT_W:0] rem_sh;
  logic [15:0] q16;

  assign px17 = 17'(in_item.pos_x);
  assign pz17 = 17'(in_item.pos_z);
  assign query_out = (17'(min_x_r) >= px17 - HALF_UNIT) || (17'(max_x_r) <= px17 + HALF_UNIT) ||
                     (17'(min_z_r) >= pz17 - HALF_UNIT) || (17'(max_z_r) <= pz17 + HALF_UNIT);
  assign copy_lim = (prod_r > 26'(GRID_CELLS)) ? (ADDR_W+1)'(GRID_CELLS) : prod_r[ADDR_W:0];
  assign dx_s = OFF_W'({accx_r, 1'b0}) - OFF_W'(span_r);
  assign dz_s = OFF_W'({accz_r, 1'b0}) - OFF_W'(span_r);
  assign px_prod = offx_r[OFF_W-2:0] * cell_scale_r;
  assign pz_prod = offz_r[OFF_W-2:0] * cell_scale_r;
  assign lin_full = {1'b0, jrl_r} + 27'(i_r);
  assign near_d = 17'(base_q_r) - 17'(dep_r);
  assign raised = 17'(base_q_r) + 17'(hgt_r);
  assign bx_inc = bx_r + 1'b1;
  assign az_inc = az_r + 1'b1;
  assign accx_inc = accx_r + ACC_W'(step_r);
  assign accz_inc = accz_r + ACC_W'(step_r);
  assign row_end = (bx_inc == SIDE_W'(MAX_SIDE_CELLS)) || (accx_inc > ACC_W'(span_r));
  assign col_end = (az_inc == SIDE_W'(MAX_SIDE_CELLS)) || (accz_inc > ACC_W'(span_r));
  assign rem_sh = {rem_r, dvd_r[SUM_W-1]};
  assign q16 = quo_r[15:0];

  assign in_item.ready = (state_r == ST_IDLE);
  assign out_item.valid = out_valid_r;
  assign out_item.depth = out_depth_r;
  assign out_item.status = out_status_r;

  always_comb begin
    state_nxt = state_r; mode_nxt = mode_r; ox2_nxt = ox2_r; oz2_nxt = oz2_r;
    span_nxt = span_r; step_nxt = step_r; hgt_nxt = hgt_r; best_nxt = best_r;
    dep_nxt = dep_r; center_nxt = center_r; skip_nxt = skip_r; outside_nxt = outside_r;
    sum_nxt = sum_r; cnt_nxt = cnt_r; bx_nxt = bx_r; az_nxt = az_r;
    accx_nxt = accx_r; accz_nxt = accz_r; offx_nxt = offx_r; offz_nxt = offz_r;
    qx_nxt = qx_r; qz_nxt = qz_r; negx_nxt = negx_r; negz_nxt = negz_r;
    i_nxt = i_r; jrl_nxt = jrl_r; lok_nxt = lok_r; sok_nxt = sok_r; lin_nxt = lin_r;
    prod_nxt = prod_r; k_nxt = k_r; cp_wr_nxt = 1'b0; cp_wa_nxt = cp_wa_r;
    dvd_nxt = dvd_r; quo_nxt = quo_r; rem_nxt = rem_r; dcnt_nxt = dcnt_r; dneg_nxt = dneg_r;
    out_valid_nxt = out_valid_r; out_depth_nxt = out_depth_r; out_status_nxt = out_status_r;
    rd_addr = lin_r;
    base_we = 1'b0; base_wa = ADDR_W'(in_item.cell_index); base_wd = in_item.cell_value;
    ov_we = cp_wr_r; ov_wa = cp_wa_r; ov_wd = base_q_r;
    sum_upd = sum_r; cnt_upd = cnt_r;

    if (out_valid_r && out_item.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_item.valid) begin
          mode_nxt = mode_t'(in_item.mode);
          hgt_nxt = in_item.height;
          skip_nxt = 1'b0; outside_nxt = 1'b0; best_nxt = OUTSIDE_DEPTH;
          sum_nxt = '0; cnt_nxt = '0; quo_nxt = '0; dneg_nxt = 1'b0;
          bx_nxt = '0; az_nxt = '0; accx_nxt = '0; accz_nxt = '0;
          ox2_nxt = 18'({px17 - 17'(min_x_r), 1'b0});
          oz2_nxt = 18'({pz17 - 17'(min_z_r), 1'b0});
          span_nxt = in_item.span;
          step_nxt = (cell_size_r != '0) ? cell_size_r : 12'd1;
          center_nxt = 1'b0;
          unique case (mode_t'(in_item.mode))
            MODE_WRITE: begin
              if (32'(in_item.cell_index) < GRID_CELLS) begin
                base_we = 1'b1;
                ov_we = 1'b1; ov_wa = ADDR_W'(in_item.cell_index);
                ov_wd = in_item.cell_value;
              end else begin
                skip_nxt = 1'b1;
              end
              state_nxt = ST_DONE;
            end
            MODE_RESET: begin
              prod_nxt = row_length_r * row_count_r;
              k_nxt = '0;
              state_nxt = ST_COPY;
            end
            MODE_RAISE: begin
              center_nxt = 1'b1;
              state_nxt = ST_OFF;
            end
            MODE_MAXB, MODE_MAXO: begin
              span_nxt = QUERY_SPAN; step_nxt = QUERY_STEP;
              if (query_out) begin
                outside_nxt = 1'b1;
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_OFF;
              end
            end
            MODE_AVG: state_nxt = ST_OFF;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_COPY: begin
        // Read base at k while the previous cell's data goes into the overlay.
        if (prod_r > 26'(GRID_CELLS)) skip_nxt = 1'b1;
        if (k_r < copy_lim) begin
          rd_addr = k_r[ADDR_W-1:0];
          cp_wr_nxt = 1'b1;
          cp_wa_nxt = k_r[ADDR_W-1:0];
          k_nxt = k_r + 1'b1;
        end else if (!cp_wr_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_OFF: begin
        offx_nxt = OFF_W'(ox2_r) + (center_r ? '0 : dx_s);
        offz_nxt = OFF_W'(oz2_r) + (center_r ? '0 : dz_s);
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        qx_nxt = px_prod[OFF_W+14:13];
        qz_nxt = pz_prod[OFF_W+14:13];
        negx_nxt = offx_r[OFF_W-1];
        negz_nxt = offz_r[OFF_W-1];
        state_nxt = ST_LIN;
      end
      ST_LIN: begin
        lok_nxt = !negx_r && !negz_r &&
                  (qx_r < Q_W'(row_length_r)) && (qz_r < Q_W'(row_count_r));
        i_nxt = qx_r[12:0];
        jrl_nxt = qz_r[12:0] * row_length_r;
        state_nxt = ST_IDX;
      end
      ST_IDX: begin
        sok_nxt = lok_r && (lin_full < 27'(GRID_CELLS));
        lin_nxt = lin_full[ADDR_W-1:0];
        rd_addr = lin_full[ADDR_W-1:0];
        state_nxt = ST_DAT;
      end
      ST_DAT: begin
        if (center_r) begin
          if (!sok_r) begin
            skip_nxt = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            dep_nxt = base_q_r;
            center_nxt = 1'b0;
            state_nxt = ST_OFF;
          end
        end else begin
          if (!sok_r) begin
            skip_nxt = 1'b1;
          end else begin
            unique case (mode_r)
              MODE_MAXB: if (base_q_r > best_r) best_nxt = base_q_r;
              MODE_MAXO: if (ov_q_r > best_r) best_nxt = ov_q_r;
              MODE_RAISE: begin
                if (near_d < NEAR_LIMIT && near_d > -NEAR_LIMIT) begin
                  ov_we = 1'b1; ov_wa = lin_r;
                  if (raised > 17'sd32767) ov_wd = 16'sd32767;
                  else if (raised < -17'sd32768) ov_wd = -16'sd32768;
                  else ov_wd = raised[15:0];
                end
              end
              MODE_AVG: begin
                sum_upd = sum_r + SUM_W'(ov_q_r);
                cnt_upd = cnt_r + 1'b1;
              end
              default: ;
            endcase
          end
          sum_nxt = sum_upd;
          cnt_nxt = cnt_upd;
          // The walk stops at the span edge or after the per-axis sample limit.
          if (bx_inc == SIDE_W'(MAX_SIDE_CELLS) && accx_inc <= ACC_W'(span_r)) skip_nxt = 1'b1;
          if (!row_end) begin
            bx_nxt = bx_inc; accx_nxt = accx_inc;
            state_nxt = ST_OFF;
          end else begin
            bx_nxt = '0; accx_nxt = '0;
            if (az_inc == SIDE_W'(MAX_SIDE_CELLS) && accz_inc <= ACC_W'(span_r))
              skip_nxt = 1'b1;
            if (!col_end) begin
              az_nxt = az_inc; accz_nxt = accz_inc;
              state_nxt = ST_OFF;
            end else if (mode_r == MODE_AVG) begin
              if (cnt_upd == '0) begin
                skip_nxt = 1'b1;
                quo_nxt = '0;
                state_nxt = ST_DONE;
              end else begin
                dneg_nxt = sum_upd[SUM_W-1];
                dvd_nxt = sum_upd[SUM_W-1] ? SUM_W'(-sum_upd) : SUM_W'(sum_upd);
                rem_nxt = '0; dcnt_nxt = '0; quo_nxt = '0;
                state_nxt = ST_DIV;
              end
            end else begin
              state_nxt = ST_DONE;
            end
          end
        end
      end
      ST_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (rem_sh >= {1'b0, cnt_r}) begin
          rem_nxt = CNT_W'(rem_sh - {1'b0, cnt_r});
          quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[CNT_W-1:0];
          quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
        end
        dvd_nxt = {dvd_r[SUM_W-2:0], 1'b0};
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DCNT_W'(SUM_W - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_item.ready) begin
          out_valid_nxt = 1'b1;
          unique case (mode_r)
            MODE_MAXB, MODE_MAXO: out_depth_nxt = best_r;
            MODE_AVG: out_depth_nxt = dneg_r ? -q16 : q16;
            default: out_depth_nxt = '0;
          endcase
          if (outside_r) out_status_nxt = STAT_OUTSIDE;
          else if (skip_r) out_status_nxt = STAT_SKIP;
          else out_status_nxt = STAT_OK;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      cp_wr_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cp_wr_r <= cp_wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt; ox2_r <= ox2_nxt; oz2_r <= oz2_nxt;
    span_r <= span_nxt; step_r <= step_nxt; hgt_r <= hgt_nxt; best_r <= best_nxt;
    dep_r <= dep_nxt; center_r <= center_nxt; skip_r <= skip_nxt; outside_r <= outside_nxt;
    sum_r <= sum_nxt; cnt_r <= cnt_nxt; bx_r <= bx_nxt; az_r <= az_nxt;
    accx_r <= accx_nxt; accz_r <= accz_nxt; offx_r <= offx_nxt; offz_r <= offz_nxt;
    qx_r <= qx_nxt; qz_r <= qz_nxt; negx_r <= negx_nxt; negz_r <= negz_nxt;
    i_r <= i_nxt; jrl_r <= jrl_nxt; lok_r <= lok_nxt; sok_r <= sok_nxt; lin_r <= lin_nxt;
    prod_r <= prod_nxt; k_r <= k_nxt; cp_wa_r <= cp_wa_nxt;
    dvd_r <= dvd_nxt; quo_r <= quo_nxt; rem_r <= rem_nxt; dcnt_r <= dcnt_nxt;
    dneg_r <= dneg_nxt;
    out_depth_r <= out_depth_nxt; out_status_r <= out_status_nxt;
  end

  `THGE_ASSERT_IMP(a_div_nonzero, state_r == ST_DIV, cnt_r != '0)
  `THGE_ASSERT_IMP(a_walk_bound, state_r == ST_DAT, bx_r < SIDE_W'(MAX_SIDE_CELLS))
  `THGE_ASSERT_IMP(a_copy_drained, state_r == ST_IDLE, !cp_wr_r)
  `THGE_ASSERT_NXT(a_done_to_out, state_r == ST_DONE && state_nxt == ST_IDLE, out_valid_r)

endmodule
`default_nettype wire
